@@ hdl/motor_text_command_classifier_defines.svh @@
// Assertion macros for the text command classifier.
// They expect clk and rst in the scope where they are used.
`ifndef MOTOR_TEXT_COMMAND_CLASSIFIER_DEFINES_SVH
`define MOTOR_TEXT_COMMAND_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define MTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mtc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, pattern table, command codes and decode functions for the text
// command classifier.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int WIN   = 16;
  localparam int NPAT  = 15;
  localparam int LEN_W = 6;

  typedef logic [WIN-1:0][7:0] win_t;
  typedef logic [NPAT-1:0]     seen_t;
  typedef logic [6:0]          code_t;
  typedef logic [LEN_W-1:0]    len_t;

  // Last character of each pattern sits in bits [7:0].
  localparam logic [8*WIN-1:0] PAT_TEXT [NPAT] = '{
    {":CL_rotenc_", "type="}, {":CL_rotenc_", "inc+"},
    {":CL_rotenc_", "type"}, {":CL_rotenc_", "inc"},
    ":ramp_mode",
    {":port_in_", "a"}, {":port_in_", "b"}, {":port_in_", "c"},
    {":port_in_", "d"}, {":port_in_", "e"}, {":port_in_", "f"},
    {":port_out_", "a"}, {":port_out_", "b"}, {":port_out_", "c"},
    {":port_out_", "d"}
  };
  localparam logic [4:0] PAT_LEN [NPAT] = '{
    5'd16, 5'd15, 5'd15, 5'd14, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd11, 5'd11, 5'd11, 5'd11
  };

  localparam int PAT_SET_ENC_TYPE = 0;
  localparam int PAT_SET_ENC_INC  = 1;
  localparam int PAT_GET_ENC_TYPE = 2;
  localparam int PAT_GET_ENC_INC  = 3;
  localparam int PAT_RAMP         = 4;
  localparam int PAT_PORT_IN      = 5;
  localparam int PAT_PORT_OUT     = 11;
  localparam int N_PORT_IN        = 6;
  localparam int N_PORT_OUT       = 4;

  localparam len_t RAMP_GET_LEN = 6'd10;
  localparam len_t IN_GET_LEN   = 6'd10;
  localparam len_t OUT_GET_LEN  = 6'd11;

  localparam code_t CODE_NONE         = 7'd0;
  localparam code_t CODE_SET_ENC_TYPE = 7'd1;
  localparam code_t CODE_SET_ENC_INC  = 7'd2;
  localparam code_t CODE_SET_ACC_JERK = 7'd3;
  localparam code_t CODE_SET_DEC_JERK = 7'd4;
  localparam code_t CODE_GET_ENC_TYPE = 7'd5;
  localparam code_t CODE_GET_ENC_INC  = 7'd6;
  localparam code_t CODE_GET_RAMP     = 7'd7;
  localparam code_t CODE_SET_RAMP     = 7'd8;
  localparam code_t CODE_GET_IN_BASE  = 7'd9;
  localparam code_t CODE_GET_OUT_BASE = 7'd21;
  localparam code_t CODE_Z_ACC_JERK   = 7'd37;
  localparam code_t CODE_Z_DEC_JERK   = 7'd38;
  localparam code_t CODE_MAX          = 7'd65;

  function automatic logic pat_hit(input win_t win, input int p);
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if (5'(k) < PAT_LEN[p] && win[k] != PAT_TEXT[p][8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic seen_t pat_hits(input win_t win);
    seen_t hits;
    for (int p = 0; p < NPAT; p++) begin
      hits[p] = pat_hit(win, p);
    end
    return hits;
  endfunction

  function automatic code_t z_lookup(input logic [7:0] c);
    code_t code;
    unique case (c)
      "h":     code = 7'd29;
      "g":     code = 7'd30;
      "i":     code = 7'd31;
      "r":     code = 7'd32;
      "l":     code = 7'd33;
      "Y":     code = 7'd34;
      "b":     code = 7'd35;
      "B":     code = 7'd36;
      "s":     code = 7'd39;
      "d":     code = 7'd40;
      "p":     code = 7'd41;
      "u":     code = 7'd42;
      "o":     code = 7'd43;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  function automatic code_t plain_lookup(input logic [7:0] c);
    code_t code;
    unique case (c)
      "v":     code = 7'd44;
      "$":     code = 7'd45;
      "g":     code = 7'd46;
      "i":     code = 7'd47;
      "r":     code = 7'd48;
      "l":     code = 7'd49;
      "L":     code = 7'd50;
      "h":     code = 7'd51;
      "Y":     code = 7'd52;
      "N":     code = 7'd53;
      "D":     code = 7'd54;
      "A":     code = 7'd55;
      "S":     code = 7'd56;
      "b":     code = 7'd57;
      "B":     code = 7'd58;
      "C":     code = 7'd59;
      "I":     code = 7'd60;
      "s":     code = 7'd61;
      "d":     code = 7'd62;
      "p":     code = 7'd63;
      "u":     code = 7'd64;
      "o":     code = 7'd65;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  function automatic code_t colon_decode(input logic [7:0] c1, input seen_t seen,
                                         input len_t len);
    code_t code;
    code = CODE_NONE;
    for (int i = N_PORT_OUT - 1; i >= 0; i--) begin
      if (seen[PAT_PORT_OUT + i]) begin
        code = CODE_GET_OUT_BASE + 7'(2 * i) + ((len == OUT_GET_LEN) ? 7'd0 : 7'd1);
      end
    end
    for (int i = N_PORT_IN - 1; i >= 0; i--) begin
      if (seen[PAT_PORT_IN + i]) begin
        code = CODE_GET_IN_BASE + 7'(2 * i) + ((len == IN_GET_LEN) ? 7'd0 : 7'd1);
      end
    end
    priority if (seen[PAT_SET_ENC_TYPE]) code = CODE_SET_ENC_TYPE;
    else if (seen[PAT_SET_ENC_INC])      code = CODE_SET_ENC_INC;
    else if (c1 == "b")                  code = CODE_SET_ACC_JERK;
    else if (c1 == "B")                  code = CODE_SET_DEC_JERK;
    else if (seen[PAT_GET_ENC_TYPE])     code = CODE_GET_ENC_TYPE;
    else if (seen[PAT_GET_ENC_INC])      code = CODE_GET_ENC_INC;
    else if (seen[PAT_RAMP])
      code = (len == RAMP_GET_LEN) ? CODE_GET_RAMP : CODE_SET_RAMP;
    else                                 code = code;
    return code;
  endfunction

  function automatic code_t classify(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [7:0] c2, input seen_t seen,
                                     input len_t len);
    code_t code;
    priority if (c0 == ":") begin
      code = colon_decode(c1, seen, len);
    end else if (c0 == "Z" && c1 == ":") begin
      priority if (c2 == "b") code = CODE_Z_ACC_JERK;
      else if (c2 == "B")     code = CODE_Z_DEC_JERK;
      else                    code = CODE_NONE;
    end else if (c0 == "Z") begin
      code = z_lookup(c1);
    end else begin
      code = plain_lookup(c0);
    end
    return code;
  endfunction

endpackage

@@ hdl/mtc_text_if.sv @@
// ----------------------------------------------------------------------------
// mtc_text_if
// Byte channel into the classifier: one text character per item.
// ----------------------------------------------------------------------------
interface mtc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

@@ hdl/mtc_result_if.sv @@
// ----------------------------------------------------------------------------
// mtc_result_if
// Result channel out of the classifier: one command code per item.
// ----------------------------------------------------------------------------
interface mtc_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] command_code;
  logic       too_long;

  modport source (output valid, command_code, too_long, input ready);
  modport sink   (input valid, command_code, too_long, output ready);
endinterface

@@ hdl/motor_text_command_classifier.sv @@
// ----------------------------------------------------------------------------
// motor_text_command_classifier
// Classifies a text command, fed one byte per item, into a command code.
// ----------------------------------------------------------------------------
// Channels: text takes one character per item with last_byte marking the end
//   of the command; a zero byte ends the text early and later bytes up to the
//   last one are ignored. result gives one item per command: command_code
//   and too_long.
// Latency: the result is valid the cycle after the last byte is taken.
// Throughput: one byte per cycle while text.ready is high; the 16-byte window
//   compare, the pattern flags and the decode are all combinational between
//   the byte and the result register.
// Stall: text.ready drops only while a result is held and result.ready is
//   low; the result register holds its item until taken.
// Reset: clears the window, pattern flags, length count and result.valid;
//   the block takes bytes in the first cycle after reset.
// MAX_LEN (16..63): texts longer than this give too_long and code 0.
// ----------------------------------------------------------------------------
module motor_text_command_classifier #(
  parameter int MAX_LEN = 40
) (
  input  logic  clk,
  input  logic  rst,
  mtc_text_if.sink     text,
  mtc_result_if.source result
);

  localparam mtc_pkg::len_t MAX_LEN_C = mtc_pkg::len_t'(MAX_LEN);

  mtc_pkg::win_t  recent;
  mtc_pkg::seen_t seen;
  logic [2:0][7:0] lead;
  mtc_pkg::len_t  len;
  logic           over;
  logic           ended;

  mtc_pkg::win_t   recent_next;
  mtc_pkg::seen_t  seen_next;
  logic [2:0][7:0] lead_next;
  mtc_pkg::len_t   len_next;
  logic            over_next;
  logic            ended_next;

  logic          accept;
  logic          take;
  mtc_pkg::code_t code_next;

  assign text.ready = !result.valid || result.ready;
  assign accept     = text.valid && text.ready;
  assign take       = !ended && (text.text_byte != 8'd0);

  always_comb begin
    recent_next = take ? {recent[mtc_pkg::WIN-2:0], text.text_byte} : recent;
    seen_next   = seen | (take ? mtc_pkg::pat_hits(recent_next) : '0);
    for (int i = 0; i < 3; i++) begin
      lead_next[i] = (take && len == mtc_pkg::LEN_W'(i)) ? text.text_byte : lead[i];
    end
    len_next   = (take && len != MAX_LEN_C) ? len + 1'b1 : len;
    over_next  = over || (take && len == MAX_LEN_C);
    ended_next = ended || (text.text_byte == 8'd0);
    code_next  = mtc_pkg::classify(lead_next[0], lead_next[1], lead_next[2],
                                   seen_next, len_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && text.last_byte)) begin
      recent <= '0;
      seen   <= '0;
      lead   <= '0;
      len    <= '0;
      over   <= 1'b0;
      ended  <= 1'b0;
    end else if (accept) begin
      recent <= recent_next;
      seen   <= seen_next;
      lead   <= lead_next;
      len    <= len_next;
      over   <= over_next;
      ended  <= ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && text.last_byte) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.last_byte) begin
      result.command_code <= over_next ? mtc_pkg::CODE_NONE : code_next;
      result.too_long     <= over_next;
    end
  end

endmodule

@@ hdl/mtc_checker.sv @@
// ----------------------------------------------------------------------------
// mtc_checker
// Port-level checks on the text command classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_text_command_classifier_defines.svh"

module mtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       text_valid,
  input logic       text_ready,
  input logic       text_last,
  input logic       res_valid,
  input logic       res_ready,
  input logic [6:0] res_code,
  input logic       res_too_long
);

  logic last_taken;
  assign last_taken = text_valid && text_ready && text_last;

  `MTC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_code) && $stable(res_too_long), "result item changed while stalled")
  `MTC_ASSERT_NEXT(a_last_gives_res, last_taken, res_valid, "no result after last byte")
  `MTC_ASSERT_NOW(a_res_from_last, $rose(res_valid), $past(last_taken), "result without last byte")
  `MTC_ASSERT_NOW(a_long_no_code, res_valid && res_too_long, res_code == mtc_pkg::CODE_NONE, "overlong text carries a code")
  `MTC_ASSERT_NOW(a_code_range, res_valid, res_code <= mtc_pkg::CODE_MAX, "command code out of range")

endmodule

bind motor_text_command_classifier mtc_checker u_mtc_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .text_last    (text.last_byte),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_code     (result.command_code),
  .res_too_long (result.too_long)
);
